/* hdl/hdt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdt_pkg: shared types and constants of the huffman tree decoder
// field widths, request and result codes, sequencer states
// ----------------------------------------------------------------------------
package hdt_pkg;

	localparam int SYM_W  = 8;
	localparam int CODE_W = 16;
	localparam int LEN_W  = 5;
	localparam int BYTE_W = 8;
	localparam int CIDX_W = $clog2(CODE_W);

	localparam int NODE_COUNT_DEF   = 512;
	localparam int MAX_CODE_LEN_DEF = 16;

	// request type codes
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_DECODE = 1'b1;

	// result kind codes
	localparam logic KIND_SYM  = 1'b0;
	localparam logic KIND_CTRL = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_MISSING = 2'd2
	} stat_t;

	typedef struct packed {
		logic             kind;
		logic [SYM_W-1:0] symbol_out;
		stat_t            status;
		logic             last;
	} result_t;

	// write strobes into the node table
	typedef struct packed {
		logic left;
		logic right;
		logic sym;
	} tbl_wen_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LD_STEP,
		ST_LD_ZERO,
		ST_DC_STEP,
		ST_DC_LEAF,
		ST_FINISH
	} state_t;

endpackage

/* hdl/hdt_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdt_req_if: request channel of the huffman tree decoder
// valid/ready handshake with load and decode payload
// ----------------------------------------------------------------------------
interface hdt_req_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [hdt_pkg::SYM_W-1:0]   symbol;
	logic [hdt_pkg::CODE_W-1:0]  code_bits;
	logic [hdt_pkg::LEN_W-1:0]   code_len;
	logic [hdt_pkg::BYTE_W-1:0]  data_byte;

	modport source (
		output valid, req_type, symbol, code_bits, code_len, data_byte,
		input  ready
	);
	modport sink (
		input  valid, req_type, symbol, code_bits, code_len, data_byte,
		output ready
	);
endinterface

/* hdl/hdt_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdt_res_if: result channel of the huffman tree decoder
// valid/ready handshake with symbol or status payload
// ----------------------------------------------------------------------------
interface hdt_res_if;
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic [hdt_pkg::SYM_W-1:0] symbol_out;
	logic [1:0]                status;
	logic                      last;

	modport source (
		output valid, kind, symbol_out, status, last,
		input  ready
	);
	modport sink (
		input  valid, kind, symbol_out, status, last,
		output ready
	);
endinterface

/* hdl/hdt_node_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdt_node_table: code tree storage
// child and symbol memories, one write and one registered read per cycle;
// the root's children live in flops so reset clears them at once
// ----------------------------------------------------------------------------
module hdt_node_table #(
	parameter int NODE_COUNT = hdt_pkg::NODE_COUNT_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   rd_en,
	input  logic [$clog2(NODE_COUNT)-1:0]          rd_addr,
	output logic [$clog2(NODE_COUNT)-1:0]          rd_left,
	output logic [$clog2(NODE_COUNT)-1:0]          rd_right,
	output logic [hdt_pkg::SYM_W-1:0]              rd_sym,
	input  hdt_pkg::tbl_wen_t                      wen,
	input  logic [$clog2(NODE_COUNT)-1:0]          wr_addr,
	input  logic [$clog2(NODE_COUNT)-1:0]          wr_left,
	input  logic [$clog2(NODE_COUNT)-1:0]          wr_right,
	input  logic [hdt_pkg::SYM_W-1:0]              wr_sym,
	output logic [$clog2(NODE_COUNT)-1:0]          root_left,
	output logic [$clog2(NODE_COUNT)-1:0]          root_right
);
	localparam int NI_W = $clog2(NODE_COUNT);

	logic [NI_W-1:0]           left_mem  [NODE_COUNT];
	logic [NI_W-1:0]           right_mem [NODE_COUNT];
	logic [hdt_pkg::SYM_W-1:0] sym_mem   [NODE_COUNT];

	logic [NI_W-1:0]           left_rd_q;
	logic [NI_W-1:0]           right_rd_q;
	logic [hdt_pkg::SYM_W-1:0] sym_rd_q;
	logic                      rd_root_q;
	logic [NI_W-1:0]           root_left_q;
	logic [NI_W-1:0]           root_right_q;
	logic                      wr_root;

	assign wr_root = (wr_addr == '0);

	always_ff @(posedge clk) begin
		if (wen.left && !wr_root) begin
			left_mem[wr_addr] <= wr_left;
		end
		if (wen.right && !wr_root) begin
			right_mem[wr_addr] <= wr_right;
		end
		if (wen.sym) begin
			sym_mem[wr_addr] <= wr_sym;
		end
		if (rd_en) begin
			left_rd_q  <= left_mem[rd_addr];
			right_rd_q <= right_mem[rd_addr];
			sym_rd_q   <= sym_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_left_q  <= '0;
			root_right_q <= '0;
			rd_root_q    <= 1'b0;
		end else begin
			if (wen.left && wr_root) begin
				root_left_q <= wr_left;
			end
			if (wen.right && wr_root) begin
				root_right_q <= wr_right;
			end
			if (rd_en) begin
				rd_root_q <= (rd_addr == '0);
			end
		end
	end

	assign rd_left    = rd_root_q ? root_left_q  : left_rd_q;
	assign rd_right   = rd_root_q ? root_right_q : right_rd_q;
	assign rd_sym     = sym_rd_q;
	assign root_left  = root_left_q;
	assign root_right = root_right_q;

endmodule

/* hdl/huffman_tree_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_decoder: huffman decoder over a node table code tree
// loads codes into a binary tree and decodes packed bytes bit by bit
// ----------------------------------------------------------------------------
// A request either loads one code (req_type 0) or decodes one data byte
// (req_type 1). A load walks its code from the root, most significant code
// bit first, allocating missing children, stores the symbol at the end node
// and answers with one result (kind 1, status ok or table full). A decode
// walks eight bits, most significant first, and returns one result per
// leaf reached (kind 0, the symbol) or per missing child (kind 1, status 2);
// a byte may yield no results at all. The walk position carries over from
// one decode byte to the next. The final result of a request has last set.
// Timing: one request is worked at a time and req.ready is high only while
// the sequencer idles. The tree walk is bound by the registered read port of
// the node table: a decode bit that steps to a child passes the step and the
// leaf state for the child read, and a bit that hits a missing child only the
// step state, around the start fetch and the closing flush. A load code bit
// reads an existing node (step, fetch) or links and clears a new node (step,
// zero), with a fetch, a closing step and the finish state around the bits.
// Results pass through a holding register and an output register, so a
// stalled result channel only stops the walk when both are occupied.
// No clearing pass is needed after reset: every node below the root has its
// children and symbol written when it is allocated, and the root's children
// are flops.
// ----------------------------------------------------------------------------
module huffman_tree_decoder #(
	parameter int NODE_COUNT   = hdt_pkg::NODE_COUNT_DEF,
	parameter int MAX_CODE_LEN = hdt_pkg::MAX_CODE_LEN_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	hdt_req_if.sink   req,
	hdt_res_if.source res
);
	localparam int NI_W = $clog2(NODE_COUNT);
	localparam int NU_W = $clog2(NODE_COUNT + 1);
	localparam int LIM  = (MAX_CODE_LEN < hdt_pkg::CODE_W) ? MAX_CODE_LEN
	                                                       : hdt_pkg::CODE_W;
	localparam logic [hdt_pkg::LEN_W-1:0] LEN_LIM  = hdt_pkg::LEN_W'(LIM);
	localparam logic [hdt_pkg::LEN_W-1:0] BYTE_CNT = hdt_pkg::LEN_W'(hdt_pkg::BYTE_W);
	localparam logic [NU_W-1:0]           FULL_CNT = NU_W'(NODE_COUNT);

	// sequencer state
	hdt_pkg::state_t state_q, state_d;

	// request context
	logic                         mode_q, mode_d;
	logic [hdt_pkg::SYM_W-1:0]    sym_q, sym_d;
	logic [hdt_pkg::CODE_W-1:0]   code_q, code_d;
	logic [hdt_pkg::BYTE_W-1:0]   byte_q, byte_d;
	logic [hdt_pkg::LEN_W-1:0]    cnt_q, cnt_d;

	// walk position and children of the current node
	logic [NI_W-1:0] p_q, p_d;
	logic [NI_W-1:0] cur_l_q, cur_l_d;
	logic [NI_W-1:0] cur_r_q, cur_r_d;
	logic [NI_W-1:0] walk_q, walk_d;
	logic [NU_W-1:0] nodes_used_q, nodes_used_d;

	// result holding and output registers
	logic              pend_valid_q;
	hdt_pkg::result_t  pend_q;
	logic              out_valid_q;
	hdt_pkg::result_t  out_q;
	hdt_pkg::result_t  out_d;
	logic              emit;
	hdt_pkg::result_t  emit_res;
	logic              flush;
	logic              load_out;
	logic              out_free;
	logic              can_emit;

	// node table port
	logic                      rd_en;
	logic [NI_W-1:0]           rd_addr;
	logic [NI_W-1:0]           rd_left;
	logic [NI_W-1:0]           rd_right;
	logic [hdt_pkg::SYM_W-1:0] rd_sym;
	hdt_pkg::tbl_wen_t         wen;
	logic [NI_W-1:0]           wr_addr;
	logic [NI_W-1:0]           wr_left;
	logic [NI_W-1:0]           wr_right;
	logic [hdt_pkg::SYM_W-1:0] wr_sym;
	logic [NI_W-1:0]           root_left;
	logic [NI_W-1:0]           root_right;

	// step helpers
	logic [hdt_pkg::LEN_W-1:0] cnt_m1;
	logic                      code_bit;
	logic [NI_W-1:0]           slot;
	logic [NI_W-1:0]           nxt;
	logic [hdt_pkg::LEN_W-1:0] len_clip;

	hdt_node_table #(
		.NODE_COUNT (NODE_COUNT)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_left    (rd_left),
		.rd_right   (rd_right),
		.rd_sym     (rd_sym),
		.wen        (wen),
		.wr_addr    (wr_addr),
		.wr_left    (wr_left),
		.wr_right   (wr_right),
		.wr_sym     (wr_sym),
		.root_left  (root_left),
		.root_right (root_right)
	);

	assign cnt_m1   = cnt_q - hdt_pkg::LEN_W'(1);
	assign code_bit = code_q[cnt_m1[hdt_pkg::CIDX_W-1:0]];
	assign slot     = code_bit ? cur_r_q : cur_l_q;
	assign nxt      = byte_q[hdt_pkg::BYTE_W-1] ? cur_r_q : cur_l_q;
	assign len_clip = (req.code_len > LEN_LIM) ? LEN_LIM : req.code_len;

	// a new result may enter when the holding slot is free or can move on
	assign out_free = !out_valid_q || res.ready;
	assign can_emit = !pend_valid_q || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hdt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		mode_d       = mode_q;
		sym_d        = sym_q;
		code_d       = code_q;
		byte_d       = byte_q;
		cnt_d        = cnt_q;
		p_d          = p_q;
		cur_l_d      = cur_l_q;
		cur_r_d      = cur_r_q;
		walk_d       = walk_q;
		nodes_used_d = nodes_used_q;
		rd_en        = 1'b0;
		rd_addr      = p_q;
		wen          = '0;
		wr_addr      = p_q;
		wr_left      = nodes_used_q[NI_W-1:0];
		wr_right     = nodes_used_q[NI_W-1:0];
		wr_sym       = sym_q;
		emit         = 1'b0;
		emit_res     = '0;
		flush        = 1'b0;

		case (state_q)
			hdt_pkg::ST_IDLE: begin
				if (req.valid) begin
					mode_d = req.req_type;
					sym_d  = req.symbol;
					code_d = req.code_bits;
					byte_d = req.data_byte;
					rd_en  = 1'b1;
					if (req.req_type == hdt_pkg::REQ_DECODE) begin
						cnt_d   = BYTE_CNT;
						rd_addr = walk_q;
						p_d     = walk_q;
					end else begin
						cnt_d   = len_clip;
						rd_addr = '0;
						p_d     = '0;
					end
					state_d = hdt_pkg::ST_FETCH;
				end
			end

			// children of the node just read become the current pair
			hdt_pkg::ST_FETCH: begin
				cur_l_d = rd_left;
				cur_r_d = rd_right;
				state_d = (mode_q == hdt_pkg::REQ_DECODE) ? hdt_pkg::ST_DC_STEP
				                                         : hdt_pkg::ST_LD_STEP;
			end

			hdt_pkg::ST_LD_STEP: begin
				if (cnt_q == '0) begin
					// code ends here: store the symbol
					wen.sym           = 1'b1;
					emit              = 1'b1;
					emit_res.kind     = hdt_pkg::KIND_CTRL;
					emit_res.status   = hdt_pkg::STAT_OK;
					state_d           = hdt_pkg::ST_FINISH;
				end else if (slot != '0) begin
					rd_en   = 1'b1;
					rd_addr = slot;
					p_d     = slot;
					cnt_d   = cnt_m1;
					state_d = hdt_pkg::ST_FETCH;
				end else if (nodes_used_q == FULL_CNT) begin
					emit            = 1'b1;
					emit_res.kind   = hdt_pkg::KIND_CTRL;
					emit_res.status = hdt_pkg::STAT_FULL;
					state_d         = hdt_pkg::ST_FINISH;
				end else begin
					// link a fresh node under the current one
					wen.left     = !code_bit;
					wen.right    = code_bit;
					p_d          = nodes_used_q[NI_W-1:0];
					nodes_used_d = nodes_used_q + NU_W'(1);
					cur_l_d      = '0;
					cur_r_d      = '0;
					cnt_d        = cnt_m1;
					state_d      = hdt_pkg::ST_LD_ZERO;
				end
			end

			// clear both children and the symbol of the node allocated last cycle
			hdt_pkg::ST_LD_ZERO: begin
				wen.left  = 1'b1;
				wen.right = 1'b1;
				wen.sym   = 1'b1;
				wr_left   = '0;
				wr_right  = '0;
				wr_sym    = '0;
				state_d   = hdt_pkg::ST_LD_STEP;
			end

			hdt_pkg::ST_DC_STEP: begin
				if (cnt_q == '0) begin
					walk_d  = p_q;
					state_d = hdt_pkg::ST_FINISH;
				end else if (nxt == '0) begin
					// missing child: report and restart at the root
					if (can_emit) begin
						emit            = 1'b1;
						emit_res.kind   = hdt_pkg::KIND_CTRL;
						emit_res.status = hdt_pkg::STAT_MISSING;
						p_d             = '0;
						cur_l_d         = root_left;
						cur_r_d         = root_right;
						byte_d          = {byte_q[hdt_pkg::BYTE_W-2:0], 1'b0};
						cnt_d           = cnt_m1;
					end
				end else begin
					rd_en   = 1'b1;
					rd_addr = nxt;
					p_d     = nxt;
					byte_d  = {byte_q[hdt_pkg::BYTE_W-2:0], 1'b0};
					cnt_d   = cnt_m1;
					state_d = hdt_pkg::ST_DC_LEAF;
				end
			end

			hdt_pkg::ST_DC_LEAF: begin
				if (rd_left == '0 && rd_right == '0) begin
					// leaf reached: emit its symbol and restart at the root
					if (can_emit) begin
						emit                = 1'b1;
						emit_res.kind       = hdt_pkg::KIND_SYM;
						emit_res.symbol_out = rd_sym;
						emit_res.status     = hdt_pkg::STAT_OK;
						p_d                 = '0;
						cur_l_d             = root_left;
						cur_r_d             = root_right;
						state_d             = hdt_pkg::ST_DC_STEP;
					end
				end else begin
					cur_l_d = rd_left;
					cur_r_d = rd_right;
					state_d = hdt_pkg::ST_DC_STEP;
				end
			end

			// send the held result out marked as the final one
			hdt_pkg::ST_FINISH: begin
				if (!pend_valid_q) begin
					state_d = hdt_pkg::ST_IDLE;
				end else if (out_free) begin
					flush   = 1'b1;
					state_d = hdt_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = hdt_pkg::ST_IDLE;
			end
		endcase
	end

	// request context and walk registers, payload only
	always_ff @(posedge clk) begin
		mode_q  <= mode_d;
		sym_q   <= sym_d;
		code_q  <= code_d;
		byte_q  <= byte_d;
		cnt_q   <= cnt_d;
		p_q     <= p_d;
		cur_l_q <= cur_l_d;
		cur_r_q <= cur_r_d;
	end

	// tree occupancy and walk position persist across requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_used_q <= NU_W'(1);
			walk_q       <= '0;
		end else begin
			nodes_used_q <= nodes_used_d;
			walk_q       <= walk_d;
		end
	end

	// a held result moves on when the next one arrives or at the end
	assign load_out = (emit && pend_valid_q) || flush;

	// held result with last set only when it closes the request
	always_comb begin
		out_d      = pend_q;
		out_d.last = flush;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit) begin
				pend_valid_q <= 1'b1;
			end else if (flush) begin
				pend_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pend_q <= emit_res;
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

	assign req.ready      = (state_q == hdt_pkg::ST_IDLE);
	assign res.valid      = out_valid_q;
	assign res.kind       = out_q.kind;
	assign res.symbol_out = out_q.symbol_out;
	assign res.status     = out_q.status;
	assign res.last       = out_q.last;

	// the node count stays within the table
	a_nodes_range: assert property (@(posedge clk) disable iff (!arst_n)
		(nodes_used_q != '0) && (nodes_used_q <= FULL_CNT))
		else $error("node count out of range");

	// nodes are allocated one at a time
	a_nodes_step: assert property (@(posedge clk) disable iff (!arst_n)
		(nodes_used_q != $past(nodes_used_q)) |->
		(nodes_used_q == $past(nodes_used_q) + NU_W'(1)))
		else $error("node count jumped");

	// the saved walk position always names an allocated node
	a_walk_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		NU_W'(walk_q) < nodes_used_q)
		else $error("walk position beyond allocated nodes");

	// nothing is held back once the sequencer is idle
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hdt_pkg::ST_IDLE) |-> !pend_valid_q)
		else $error("result held while idle");

	// a flushed final result is presented at the output with last set
	a_last_order: assert property (@(posedge clk) disable iff (!arst_n)
		flush |=> (out_valid_q && out_q.last))
		else $error("final result not presented");

endmodule
